>>> design/kinl_pkg.sv
package kinl_pkg;

  typedef enum logic [3:0] {
    K_INT     = 4'd0,
    K_IF      = 4'd1,
    K_IDENT   = 4'd2,
    K_NUMBER  = 4'd3,
    K_ASSIGN  = 4'd4,
    K_PLUS    = 4'd5,
    K_MINUS   = 4'd6,
    K_SEMI    = 4'd7,
    K_LBRACE  = 4'd8,
    K_RBRACE  = 4'd9,
    K_LPAREN  = 4'd10,
    K_RPAREN  = 4'd11,
    K_END     = 4'd12,
    K_UNKNOWN = 4'd13
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start_res;
    logic [6:0]  length;
    logic [7:0]  char_value;
    logic        last;
  } tok_t;

  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_ASSIGN = 8'h3d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_ASSIGN: k = K_ASSIGN;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_SEMI:   k = K_SEMI;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

>>> design/kinl_lex.sv
module kinl_lex #(
  parameter logic [6:0] LEN_CAP = 7'd99
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     ch,
  input  logic           is_end,
  output kinl_pkg::tok_t res0,
  output kinl_pkg::tok_t res1,
  output logic [1:0]     res_count
);
  import kinl_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE   = 2'd0,
    M_IDENT  = 2'd1,
    M_NUMBER = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_I    = 2'd1,
    KW_IN   = 2'd2,
    KW_IF   = 2'd3
  } kw_t;

  mode_t       mode, mode_next;
  logic [31:0] token_start, token_start_next;
  logic [6:0]  token_length, token_length_next;
  kw_t         keyword_match, keyword_match_next;
  logic [31:0] position, position_next;

  logic  alpha, digit, ws, pending, cont;
  tok_t  flush_tok, idle_tok;
  logic  idle_emit;

  always_comb begin
    alpha   = is_alpha(ch);
    digit   = is_digit(ch);
    ws      = is_ws(ch);
    pending = (mode == M_IDENT) || (mode == M_NUMBER);
    cont    = ((mode == M_IDENT) && (alpha || digit)) || ((mode == M_NUMBER) && digit);

    flush_tok            = '0;
    flush_tok.start_res  = token_start;
    flush_tok.length     = token_length;
    if (mode == M_NUMBER) begin
      flush_tok.kind = K_NUMBER;
    end else if (keyword_match == KW_IN && token_length == 7'd3) begin
      flush_tok.kind = K_INT;
    end else if (keyword_match == KW_IF && token_length == 7'd2) begin
      flush_tok.kind = K_IF;
    end else begin
      flush_tok.kind = K_IDENT;
    end

    idle_tok            = '0;
    idle_tok.kind       = punct_kind(ch);
    idle_tok.start_res  = position;
    idle_tok.length     = 7'd1;
    idle_tok.char_value = ch;
    idle_tok.last       = 1'b1;
    idle_emit           = !(ws || alpha || digit);

    mode_next          = mode;
    token_start_next   = token_start;
    token_length_next  = token_length;
    keyword_match_next = keyword_match;
    position_next      = position;
    res0               = '0;
    res1               = '0;
    res_count          = 2'd0;

    if (is_end) begin
      mode_next = M_IDLE;
      res1           = '0;
      res1.kind      = K_END;
      res1.start_res = position;
      res1.last      = 1'b1;
      if (pending) begin
        res0      = flush_tok;
        res_count = 2'd2;
      end else begin
        res0      = res1;
        res_count = 2'd1;
      end
    end else begin
      position_next = position + 32'd1;
      if (cont) begin
        if (token_length < LEN_CAP) begin
          token_length_next = token_length + 7'd1;
          if (mode == M_IDENT) begin
            if (token_length == 7'd1 && keyword_match == KW_I) begin
              keyword_match_next = (ch == CH_N) ? KW_IN : (ch == CH_F) ? KW_IF : KW_NONE;
            end else if (token_length == 7'd2 && keyword_match == KW_IN && ch == CH_T) begin
              keyword_match_next = KW_IN;
            end else begin
              keyword_match_next = KW_NONE;
            end
          end
        end
      end else begin
        mode_next = M_IDLE;
        if (alpha || digit) begin
          mode_next          = alpha ? M_IDENT : M_NUMBER;
          token_start_next   = position;
          token_length_next  = 7'd1;
          keyword_match_next = (alpha && ch == CH_I) ? KW_I : KW_NONE;
        end
        if (pending) begin
          res0 = flush_tok;
          if (idle_emit) begin
            res1      = idle_tok;
            res_count = 2'd2;
          end else begin
            res0.last = 1'b1;
            res_count = 2'd1;
          end
        end else if (idle_emit) begin
          res0      = idle_tok;
          res_count = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      token_start   <= '0;
      token_length  <= '0;
      keyword_match <= KW_NONE;
      position      <= '0;
    end else if (step) begin
      mode          <= mode_next;
      token_start   <= token_start_next;
      token_length  <= token_length_next;
      keyword_match <= keyword_match_next;
      position      <= position_next;
    end
  end

endmodule

>>> design/kinl_outq.sv
module kinl_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_count,
  input  kinl_pkg::tok_t push0,
  input  kinl_pkg::tok_t push1,
  input  logic           stall,
  output logic           valid,
  output kinl_pkg::tok_t head_tok,
  output logic           room
);
  import kinl_pkg::*;

  localparam int Depth = 4;
  localparam int AddrW = 2;
  localparam int CountW = 3;

  tok_t              entries [Depth];
  logic [AddrW-1:0]  head, tail;
  logic [CountW-1:0] count;
  logic              pop;

  assign valid    = (count != '0);
  assign pop      = valid && !stall;
  assign head_tok = entries[head];
  assign room     = (count <= CountW'(Depth - 2)) || ((count == CountW'(Depth - 1)) && pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[tail] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[tail + AddrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + AddrW'(push_count);
      head  <= head + AddrW'(pop);
      count <= count + CountW'(push_count) - CountW'(pop);
    end
  end

endmodule

>>> design/keyword_ident_number_lexer.sv
// Byte-serial lexer: one source byte (or end marker) per src transfer, one token per
// tok transfer. Bytes are taken one per cycle while the queue has room; each passes
// an input register, is lexed combinationally against the token state and its zero,
// one or two tokens land in a four-entry result queue. Tokens leave at most one per
// cycle, so the output sets the sustained rate: a byte that both ends an identifier
// or number and forms a token of its own yields two tokens. Tokens are read from the
// queue, behind the input register. Lengths saturate at MAX_TEXT-1 (at most 127).
module keyword_ident_number_lexer #(
  parameter int MAX_TEXT = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  ch,
  input  logic        is_end,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [3:0]  kind,
  output logic [31:0] start_res,
  output logic [6:0]  length,
  output logic [7:0]  char_value,
  output logic        last
);
  import kinl_pkg::*;

  localparam logic [6:0] LenCap = (MAX_TEXT - 1 > 127) ? 7'd127 : 7'(MAX_TEXT - 1);

  logic       src_full;
  logic [7:0] src_ch;
  logic       src_is_end;
  logic       room, step;
  tok_t       res0, res1, head_tok;
  logic [1:0] res_count;

  assign step      = src_full && room;
  assign src_stall = src_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_full <= 1'b0;
    end else if (src_valid && !src_stall) begin
      src_full <= 1'b1;
    end else if (step) begin
      src_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      src_ch     <= ch;
      src_is_end <= is_end;
    end
  end

  kinl_lex #(
    .LEN_CAP(LenCap)
  ) u_lex (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .ch       (src_ch),
    .is_end   (src_is_end),
    .res0     (res0),
    .res1     (res1),
    .res_count(res_count)
  );

  kinl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_count(step ? res_count : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .stall     (tok_stall),
    .valid     (tok_valid),
    .head_tok  (head_tok),
    .room      (room)
  );

  assign kind       = head_tok.kind;
  assign start_res  = head_tok.start_res;
  assign length     = head_tok.length;
  assign char_value = head_tok.char_value;
  assign last       = head_tok.last;

endmodule
